[rtl/assert_macros.svh]
// Assertion macros used by the sorter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define DS_ASSERT(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DS_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DS_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/desort_pkg.sv]
// Types and constants of the descending exchange sorter.
package desort_pkg;

  localparam int DATA_W          = 32;
  localparam int MAX_ITEMS_DEF   = 8;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_HEAD,
    ST_LOAD_CUR,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

[rtl/descending_exchange_sorter_unit.sv]
// Descending exchange sorter: top level with buffer RAM and sort sequencer.
//
// Collects a run of signed 32-bit values (one transfer each, the final one
// flagged by last) into a MAX_ITEMS-entry buffer RAM, sorts it largest first
// by exchange sort, and streams the sorted run out with final_res on the
// last result. Items past capacity are dropped and truncated is set on
// every result of that run; a last item arriving on a full buffer still
// ends the run. Equal values keep no particular guarantee beyond the
// exchange-sort order: they are never swapped. Timing: while loading, one
// input transfer per cycle. After the last transfer item_stall stays high
// for the whole sort and emit phase. The sort speed is bounded by the
// single compare unit and the single read port of the buffer RAM: each
// compare-exchange step reads one entry. Row i keeps its running maximum
// in a register, so a finished row is emitted straight from that
// register with no extra read-back pass.
`include "assert_macros.svh"

module descending_exchange_sorter_unit #(
  parameter int MAX_ITEMS = desort_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic signed [desort_pkg::DATA_W-1:0] value,
  input  logic                              last,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [desort_pkg::DATA_W-1:0] sorted_value,
  output logic                              final_res,
  output logic                              truncated
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // sequencer registers
  desort_pkg::state_t state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;     // fill count, then run length
  logic               ovf, ovf_next;     // an item of this run was dropped
  logic [CNT_W-1:0]   row, row_next;     // position being settled
  logic [CNT_W-1:0]   col, col_next;     // later position being compared
  logic signed [desort_pkg::DATA_W-1:0] cur, cur_next;  // running max of row

  // buffer RAM port
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [desort_pkg::DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]              ram_raddr;
  logic [desort_pkg::DATA_W-1:0] ram_rdata;

  logic             in_xfer;
  logic             out_xfer;
  logic             room;
  logic [CNT_W-1:0] col_inc;
  logic [CNT_W-1:0] row_inc;
  logic [CNT_W-1:0] row_inc2;
  logic             swap;

  desort_ram #(
    .WIDTH (desort_pkg::DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign item_stall   = (state != desort_pkg::ST_LOAD);
  assign in_xfer      = item_valid && !item_stall;
  assign result_valid = (state == desort_pkg::ST_EMIT);
  assign out_xfer     = result_valid && !result_stall;

  assign room     = (cnt < CNT_W'(MAX_ITEMS));
  assign col_inc  = col + CNT_W'(1);
  assign row_inc  = row + CNT_W'(1);
  assign row_inc2 = row + CNT_W'(2);
  // signed compare: a later entry strictly larger than the running max
  assign swap     = (cur < $signed(ram_rdata));

  // results come straight from the row register
  assign sorted_value = cur;
  assign final_res    = (row_inc == cnt);
  assign truncated    = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= desort_pkg::ST_LOAD;
      cnt   <= '0;
      ovf   <= 1'b0;
      row   <= '0;
      col   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ovf   <= ovf_next;
      row   <= row_next;
      col   <= col_next;
    end
    cur <= cur_next;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ovf_next   = ovf;
    row_next   = row;
    col_next   = col;
    cur_next   = cur;
    ram_we     = 1'b0;
    ram_waddr  = col[IDX_W-1:0];
    ram_wdata  = cur;
    ram_raddr  = row_inc[IDX_W-1:0];

    case (state)
      desort_pkg::ST_LOAD: begin
        if (in_xfer) begin
          if (room) begin
            ram_we    = 1'b1;
            ram_waddr = cnt[IDX_W-1:0];
            ram_wdata = value;
            cnt_next  = cnt + CNT_W'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (last) begin
            row_next   = '0;
            state_next = desort_pkg::ST_HEAD;
          end
        end
      end

      desort_pkg::ST_HEAD: begin
        // fetch the first entry; run holds at least one value
        ram_raddr  = '0;
        col_next   = CNT_W'(1);
        state_next = desort_pkg::ST_LOAD_CUR;
      end

      desort_pkg::ST_LOAD_CUR: begin
        cur_next  = ram_rdata;
        ram_raddr = col[IDX_W-1:0];
        if (col < cnt) begin
          state_next = desort_pkg::ST_SCAN;
        end else begin
          state_next = desort_pkg::ST_EMIT;
        end
      end

      desort_pkg::ST_SCAN: begin
        // rdata holds entry col; prefetch col + 1
        if (swap) begin
          ram_we    = 1'b1;
          ram_waddr = col[IDX_W-1:0];
          ram_wdata = cur;
          cur_next  = ram_rdata;
        end
        ram_raddr = col_inc[IDX_W-1:0];
        col_next  = col_inc;
        if (col_inc >= cnt) begin
          state_next = desort_pkg::ST_EMIT;
        end
      end

      desort_pkg::ST_EMIT: begin
        // raddr presents row + 1 so the next row starts on transfer
        if (out_xfer) begin
          if (final_res) begin
            cnt_next   = '0;
            ovf_next   = 1'b0;
            state_next = desort_pkg::ST_LOAD;
          end else begin
            row_next   = row_inc;
            col_next   = row_inc2;
            state_next = desort_pkg::ST_LOAD_CUR;
          end
        end
      end

      default: begin
        state_next = desort_pkg::ST_LOAD;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  `DS_ASSERT(a_cnt_bound, clk, rst, cnt <= CNT_W'(MAX_ITEMS), "fill count past capacity")
  `DS_IMPLY(a_load_room, clk, rst, ram_we && state == desort_pkg::ST_LOAD, room, "write to full buffer")
  `DS_IMPLY(a_swap_ahead, clk, rst, ram_we && state == desort_pkg::ST_SCAN, col > row && col < cnt, "exchange outside the unsorted tail")
  `DS_IMPLY(a_emit_row, clk, rst, result_valid, row < cnt, "result beyond run length")
  `DS_NEXT(a_run_clears, clk, rst, out_xfer && final_res, state == desort_pkg::ST_LOAD && cnt == '0 && !ovf, "run state not cleared after final result")

endmodule

[rtl/desort_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module desort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
